// File: hw/rtl/awf_pkg.sv
// shared types, opcodes and widths for the arm alu with flags block
package awf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 4;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;
  localparam logic [DataW-1:0] PcAhead = 32'd8;

  // data-processing opcodes; the two codes above mvn are unused
  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_AND = 4'd2,
    OP_BIC = 4'd3,
    OP_EOR = 4'd4,
    OP_ORR = 4'd5,
    OP_RSB = 4'd6,
    OP_RSC = 4'd7,
    OP_SUB = 4'd8,
    OP_SBC = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_MOV = 4'd12,
    OP_MVN = 4'd13
  } awf_op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } awf_nzcv_t;

  // one operation as held in the input register
  typedef struct packed {
    logic [OpW-1:0]   req_type;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             shifter_carry;
    logic             set_flags;
    logic             a_is_pc;
  } awf_req_t;

  // one result as held in the output register
  typedef struct packed {
    logic [DataW-1:0] alu_result;
    logic             write_result;
    awf_nzcv_t        flags;
  } awf_res_t;

endpackage

// File: hw/rtl/awf_alu.sv
// combinational alu: one adder with carry-in, logic ops and nzcv update
module awf_alu (
  input  awf_pkg::awf_req_t  req,
  input  awf_pkg::awf_nzcv_t flags_cur,
  output awf_pkg::awf_res_t  res
);
  import awf_pkg::*;

  logic [DataW-1:0] a_eff;
  logic [DataW-1:0] add_x;
  logic [DataW-1:0] add_y;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_r;
  logic             add_v;
  logic [DataW-1:0] result;
  logic             wr;
  logic             is_arith;
  logic             is_logic;
  logic             force_flags;
  logic             upd;
  awf_nzcv_t        flags_new;

  // pc read-ahead on the first operand
  assign a_eff = req.a_is_pc ? (req.operand_a + PcAhead) : req.operand_a;

  // adder operand selection
  always_comb begin
    add_x   = a_eff;
    add_y   = req.operand_b;
    add_cin = 1'b0;
    unique case (awf_op_t'(req.req_type))
      OP_ADC: begin
        add_cin = flags_cur.c;
      end
      OP_RSB: begin
        add_x   = req.operand_b;
        add_y   = ~a_eff;
        add_cin = 1'b1;
      end
      OP_RSC: begin
        add_x   = req.operand_b;
        add_y   = ~a_eff;
        add_cin = flags_cur.c;
      end
      OP_SUB, OP_CMP: begin
        add_y   = ~req.operand_b;
        add_cin = 1'b1;
      end
      OP_SBC: begin
        add_y   = ~req.operand_b;
        add_cin = flags_cur.c;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_r   = add_sum[DataW-1:0];
  assign add_v   = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ add_r[DataW-1]);

  // result select and operation class
  always_comb begin
    result      = '0;
    wr          = 1'b1;
    is_arith    = 1'b0;
    is_logic    = 1'b0;
    force_flags = 1'b0;
    unique case (awf_op_t'(req.req_type))
      OP_ADD, OP_ADC, OP_RSB, OP_RSC, OP_SUB, OP_SBC: begin
        result   = add_r;
        is_arith = 1'b1;
      end
      OP_CMP, OP_CMN: begin
        result      = add_r;
        is_arith    = 1'b1;
        wr          = 1'b0;
        force_flags = 1'b1;
      end
      OP_AND: begin
        result   = a_eff & req.operand_b;
        is_logic = 1'b1;
      end
      OP_BIC: begin
        result   = a_eff & ~req.operand_b;
        is_logic = 1'b1;
      end
      OP_EOR: begin
        result   = a_eff ^ req.operand_b;
        is_logic = 1'b1;
      end
      OP_ORR: begin
        result   = a_eff | req.operand_b;
        is_logic = 1'b1;
      end
      OP_MOV: begin
        result = req.operand_b;
      end
      OP_MVN: begin
        result = ~req.operand_b;
      end
      default: begin
        result = '0;
        wr     = 1'b0;
      end
    endcase
  end

  // nzcv update: arithmetic takes c and v from the adder, logic takes c from the shifter
  assign upd = (is_arith & (req.set_flags | force_flags)) | (is_logic & req.set_flags);

  always_comb begin
    flags_new = flags_cur;
    if (upd) begin
      flags_new.n = result[DataW-1];
      flags_new.z = (result == '0);
      flags_new.c = is_arith ? add_sum[DataW] : req.shifter_carry;
      flags_new.v = is_arith ? add_v : flags_cur.v;
    end
  end

  assign res.alu_result   = result;
  assign res.write_result = wr;
  assign res.flags        = flags_new;

endmodule

// File: hw/rtl/arm_alu_with_flags_core.sv
// top level: input register, alu, nzcv register and output register
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  in_     | in  | req_type, operand_a, operand_b, shifter_carry,      | a_is_pc
//          |     | set_flags, zero pad to 72 bits                      |
//  out_    | out | alu_result, write_result, flag_n, flag_z, flag_c,   | none
//          |     | flag_v, zero pad to 40 bits                         |
//
// one item per cycle unless out_tready stalls; items go through the input and output registers
// the nzcv register loops through the alu, so adc/sbc/rsc see the previous item's carry
// rst_n is synchronous: empties both registers and clears nzcv
// a stall on out_tready holds the output register; the input register still fills,
// and in_tready drops only when both are full
module arm_alu_with_flags_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [awf_pkg::InDataW-1:0]  in_tdata,   // req_type, operand_a, operand_b,
                                                   // shifter_carry, set_flags, pad
  input  logic                         in_tuser,   // a_is_pc
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [awf_pkg::OutDataW-1:0] out_tdata   // alu_result, write_result, flag_n,
                                                   // flag_z, flag_c, flag_v, pad
);
  import awf_pkg::*;

  logic      in_valid_r;
  awf_req_t  in_req_r;
  awf_req_t  in_req_nxt;
  logic      out_valid_r;
  awf_res_t  out_res_r;
  awf_res_t  alu_res;
  awf_nzcv_t flags_r;
  logic      advance;
  logic      in_xfer;

  // unpack the input transfer
  assign in_req_nxt.req_type      = in_tdata[3:0];
  assign in_req_nxt.operand_a     = in_tdata[35:4];
  assign in_req_nxt.operand_b     = in_tdata[67:36];
  assign in_req_nxt.shifter_carry = in_tdata[68];
  assign in_req_nxt.set_flags     = in_tdata[69];
  assign in_req_nxt.a_is_pc       = in_tuser;

  // handshake
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_xfer   = in_tvalid & in_tready;

  awf_alu u_alu (
    .req       (in_req_r),
    .flags_cur (flags_r),
    .res       (alu_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= alu_res.flags;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_req_r <= in_req_nxt;
    end
    if (advance) begin
      out_res_r <= alu_res;
    end
  end

  // pack the result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.flags.v, out_res_r.flags.c, out_res_r.flags.z,
                       out_res_r.flags.n, out_res_r.write_result, out_res_r.alu_result};

endmodule

// File: hw/rtl/awf_checker.sv
// port-level checks for the alu core, bound to the top level
module awf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [awf_pkg::OutDataW-1:0] out_tdata
);
  import awf_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // n and z come from one result, so they are never both set
  a_nz_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[33] && out_tdata[34]))
    else $error("flags n and z both set");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:37] == 3'b000)
    else $error("nonzero pad bits in result");

endmodule

bind arm_alu_with_flags_core awf_checker u_awf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb_top.sv
// testbench for arm_alu_with_flags_core: directed, carry chain and random alu operations
module tb_top;
  import awf_pkg::*;

  // codes above mvn that the block treats as no-ops
  localparam logic [OpW-1:0] OP_SPARE_LO = 4'd14;
  localparam logic [OpW-1:0] OP_SPARE_HI = 4'd15;
  localparam int unsigned    IdleLimit   = 5000;
  localparam int unsigned    SettleCyc   = 8;
  localparam int unsigned    RandomOps   = 1500;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  awf_res_t   expected_results[$];
  awf_nzcv_t  flags_model    = '0;
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  int         stall_left     = 0;
  bit         tx_idle_en     = 1'b0;
  bit         rx_idle_en     = 1'b0;

  arm_alu_with_flags_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // expected result and flags of one operation given the current nzcv
  function automatic awf_res_t predict_alu(input awf_req_t rq, input awf_nzcv_t cur);
    logic [DataW-1:0] a;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] r;
    logic [DataW:0]   sum;
    logic             cin;
    logic             cout;
    logic             ovf;
    logic             arith;
    logic             logic_op;
    logic             upd;
    logic             wr;
    awf_res_t         res;
    a        = rq.a_is_pc ? rq.operand_a + PcAhead : rq.operand_a;
    x        = '0;
    y        = '0;
    r        = '0;
    cin      = 1'b0;
    cout     = 1'b0;
    ovf      = 1'b0;
    arith    = 1'b0;
    logic_op = 1'b0;
    upd      = rq.set_flags;
    wr       = 1'b1;
    case (rq.req_type)
      OP_ADD: begin x = a; y = rq.operand_b; arith = 1'b1; end
      OP_ADC: begin x = a; y = rq.operand_b; cin = cur.c; arith = 1'b1; end
      OP_AND: begin r = a & rq.operand_b; logic_op = 1'b1; end
      OP_BIC: begin r = a & ~rq.operand_b; logic_op = 1'b1; end
      OP_EOR: begin r = a ^ rq.operand_b; logic_op = 1'b1; end
      OP_ORR: begin r = a | rq.operand_b; logic_op = 1'b1; end
      OP_RSB: begin x = rq.operand_b; y = ~a; cin = 1'b1; arith = 1'b1; end
      OP_RSC: begin x = rq.operand_b; y = ~a; cin = cur.c; arith = 1'b1; end
      OP_SUB: begin x = a; y = ~rq.operand_b; cin = 1'b1; arith = 1'b1; end
      OP_SBC: begin x = a; y = ~rq.operand_b; cin = cur.c; arith = 1'b1; end
      OP_CMP: begin
        x = a; y = ~rq.operand_b; cin = 1'b1; arith = 1'b1; wr = 1'b0; upd = 1'b1;
      end
      OP_CMN: begin
        x = a; y = rq.operand_b; arith = 1'b1; wr = 1'b0; upd = 1'b1;
      end
      OP_MOV: r = rq.operand_b;
      OP_MVN: r = ~rq.operand_b;
      default: wr = 1'b0;
    endcase
    // one adder serves every arithmetic opcode
    if (arith) begin
      sum  = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, cin};
      r    = sum[DataW-1:0];
      cout = sum[DataW];
      ovf  = ~(x[DataW-1] ^ y[DataW-1]) & (x[DataW-1] ^ r[DataW-1]);
    end
    res.alu_result   = r;
    res.write_result = wr;
    res.flags        = cur;
    if (upd && (arith || logic_op)) begin
      res.flags.n = r[DataW-1];
      res.flags.z = (r == '0);
      res.flags.c = arith ? cout : rq.shifter_carry;
      res.flags.v = arith ? ovf : cur.v;
    end
    return res;
  endfunction

  function automatic awf_req_t mk_req(input logic [OpW-1:0] op, input logic [DataW-1:0] a,
                                      input logic [DataW-1:0] b, input logic sc,
                                      input logic s, input logic pc);
    awf_req_t rq;
    rq.req_type      = op;
    rq.operand_a     = a;
    rq.operand_b     = b;
    rq.shifter_carry = sc;
    rq.set_flags     = s;
    rq.a_is_pc       = pc;
    return rq;
  endfunction

  // corner values often, plain random words otherwise
  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 15);
      5: return 32'hffff_fff0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic awf_req_t rand_req(input logic [OpW-1:0] op);
    awf_req_t rq;
    rq = mk_req(op, rand_operand(), rand_operand(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
    // equal or negated operands hit zero results and carries
    case ($urandom_range(0, 15))
      0, 1: rq.operand_b = rq.operand_a;
      2:    rq.operand_b = ~rq.operand_a + 1'b1;
      default: ;
    endcase
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    mismatch_count++;
  endtask

  // one input transfer; the prediction is made once it is accepted
  task automatic send_op(input awf_req_t rq);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rq.set_flags, rq.shifter_carry, rq.operand_b, rq.operand_a,
                  rq.req_type};
    in_tuser  <= rq.a_is_pc;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_alu(rq, flags_model));
    flags_model = expected_results[$].flags;
  endtask

  // hold the sender until every expected result has arrived
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // extremes, every opcode, spare codes, pc read-ahead and flag keeping
  task automatic test_directed_ops();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_op(mk_req(OP_ADD, 32'hffff_ffff, 32'h1, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_ADC, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_ADD, 32'h7fff_ffff, 32'h1, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_AND, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b1, 1'b0));
    send_op(mk_req(OP_BIC, 32'h0f0f_0f0f, 32'h0f0f_0f0f, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_EOR, 32'hffff_ffff, 32'h5555_aaaa, 1'b1, 1'b0, 1'b0));
    send_op(mk_req(OP_ORR, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0));
    send_op(mk_req(OP_RSB, 32'h1, 32'h0, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_RSC, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_SUB, 32'h0, 32'h1, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_SBC, 32'h5, 32'h3, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_CMP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0, 1'b0));
    send_op(mk_req(OP_CMN, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_op(mk_req(OP_MOV, 32'hdead_beef, 32'h0, 1'b1, 1'b1, 1'b0));
    send_op(mk_req(OP_MVN, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1));
    send_op(mk_req(OP_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1));
    send_op(mk_req(OP_SPARE_HI, 32'h1, 32'h1, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_ADD, 32'hffff_fff8, 32'h0, 1'b0, 1'b1, 1'b1));
    send_op(mk_req(OP_SUB, 32'hffff_fffc, 32'h4, 1'b0, 1'b1, 1'b1));
    send_op(mk_req(OP_CMP, 32'h7fff_fffc, 32'hffff_ffff, 1'b1, 1'b0, 1'b1));
    send_op(mk_req(OP_ADC, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, 1'b0));
    send_op(mk_req(OP_SBC, 32'h8000_0000, 32'h0, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_EOR, 32'hffff_ffff, 32'h0, 1'b0, 1'b1, 1'b0));
    send_op(mk_req(OP_RSB, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1));
  endtask

  // multiword add and subtract: a flag setting head then carry consuming ops
  task automatic test_carry_chains();
    awf_req_t  rq;
    logic [OpW-1:0] tail_op;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 2))
        0: begin rq = rand_req(OP_ADD); tail_op = OP_ADC; end
        1: begin rq = rand_req(OP_SUB); tail_op = OP_SBC; end
        default: begin rq = rand_req(OP_RSB); tail_op = OP_RSC; end
      endcase
      rq.set_flags = 1'b1;
      send_op(rq);
      repeat ($urandom_range(1, 4)) begin
        rq = rand_req(tail_op);
        rq.set_flags = ($urandom_range(0, 4) != 0);
        send_op(rq);
      end
    end
  endtask

  // random opcodes, singles and chains, with idling switched per block
  task automatic test_random_ops();
    awf_req_t rq;
    int       sent;
    int       block_end;
    sent = 0;
    while (sent < RandomOps) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      block_end  = sent + 100;
      while (sent < block_end) begin
        if ($urandom_range(0, 9) < 3) begin
          rq = rand_req(($urandom_range(0, 1) != 0) ? OP_ADD : OP_SUB);
          rq.set_flags = 1'b1;
          send_op(rq);
          sent++;
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: rq = rand_req(OP_ADC);
              1: rq = rand_req(OP_SBC);
              2: rq = rand_req(OP_RSC);
              default: rq = rand_req(OP_CMP);
            endcase
            send_op(rq);
            sent++;
          end
        end else begin
          send_op(rand_req(OpW'($urandom_range(0, 15))));
          sent++;
        end
      end
      if ($urandom_range(0, 4) == 0) wait_results_drained();
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    awf_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_tdata[DataW-1:0]);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.alu_result)
          report_mismatch("alu_result", want.alu_result, out_tdata[31:0]);
        if (out_tdata[32] !== want.write_result)
          report_mismatch("write_result", DataW'(want.write_result), DataW'(out_tdata[32]));
        if (out_tdata[33] !== want.flags.n)
          report_mismatch("flag_n", DataW'(want.flags.n), DataW'(out_tdata[33]));
        if (out_tdata[34] !== want.flags.z)
          report_mismatch("flag_z", DataW'(want.flags.z), DataW'(out_tdata[34]));
        if (out_tdata[35] !== want.flags.c)
          report_mismatch("flag_c", DataW'(want.flags.c), DataW'(out_tdata[35]));
        if (out_tdata[36] !== want.flags.v)
          report_mismatch("flag_v", DataW'(want.flags.v), DataW'(out_tdata[36]));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_carry_chains();
    wait_results_drained();
    test_random_ops();
    wait_results_drained();
    repeat (SettleCyc) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
